/* design/limiter_gain_computer_core_defines.svh */
// assertion macros for the limiter gain computer core
`ifndef LIMITER_GAIN_COMPUTER_CORE_DEFINES_SVH
`define LIMITER_GAIN_COMPUTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LGC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define LGC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lgc_pkg.sv */
package lgc_pkg;

    localparam int SAMPLE_BITS_DEF = 24;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] IDX_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_KNEE_W    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_KNEE_MODE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_MAKEUP    = 8'd3;

    localparam logic signed [15:0] THR_MIN = -16'sd20480;
    localparam logic [12:0]        KW_MAX  = 13'd6144;
    localparam logic signed [13:0] MU_MIN  = -14'sd6144;
    localparam logic signed [13:0] MU_MAX  = 14'sd6144;

    // curve region codes
    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_LIN  = 2'd1;
    localparam logic [1:0] SEL_SOFT = 2'd2;

    // soft-knee divider: numerator, divisor and quotient widths
    localparam int DIV_NW = 28;
    localparam int DIV_DW = 16;
    localparam int DIV_QW = 12;

    localparam logic [29:0] LOG2_10_OVER_20_Q32 = 30'd713378626;
    localparam logic [31:0] LN2_Q32             = 32'd2977044472;

    localparam int N_TERMS  = 13;
    localparam int RECIP_SH = 35;
    localparam int EXP_LAT  = 1 + 3 * N_TERMS;

endpackage

/* design/lgc_div.sv */
module lgc_div #(
    parameter int NW = lgc_pkg::DIV_NW,
    parameter int DW = lgc_pkg::DIV_DW,
    parameter int QW = lgc_pkg::DIV_QW
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    // restoring division, one quotient bit per stage, msb first
    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [NW:0]   n_trial;
        logic          n_ge;

        if (i == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign den_in = r_den[i-1];
            assign quo_in = r_quo[i-1];
        end

        assign n_trial = (NW+1)'(den_in) << (QW - 1 - i);
        assign n_ge    = (NW+1)'(rem_in) >= n_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= n_ge ? NW'((NW+1)'(rem_in) - n_trial) : rem_in;
                r_den[i] <= den_in;
                r_quo[i] <= quo_in | (n_ge ? (QW'(1) << (QW - 1 - i)) : '0);
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

/* design/lgc_exp.sv */
module lgc_exp (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_frac,
    output logic [33:0] o_sum
);
    // 2^frac as a truncated exp series in Q32, three stages per term
    localparam int NT = lgc_pkg::N_TERMS;
    localparam int SH = lgc_pkg::RECIP_SH;

    logic [31:0] r_y0;
    logic [31:0] r_v1  [1:NT];
    logic [31:0] r_y1  [1:NT];
    logic [33:0] r_s1  [1:NT];
    logic [31:0] r_v2  [1:NT];
    logic [67:0] r_qm2 [1:NT];
    logic [31:0] r_y2  [1:NT];
    logic [33:0] r_s2  [1:NT];
    logic [32:0] r_t3  [1:NT];
    logic [31:0] r_y3  [1:NT];
    logic [33:0] r_s3  [1:NT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y0 <= 32'((64'(i_frac) * 64'(lgc_pkg::LN2_Q32)) >> 32);
        end
    end

    for (genvar k = 1; k <= NT; k++) begin : g_term
        // reciprocal of k, low by at most one after the shift
        localparam logic [35:0] MK = 36'((64'd1 << SH) / k);

        logic [32:0] t_in;
        logic [31:0] y_in;
        logic [33:0] s_in;
        logic [31:0] n_q0;
        logic [35:0] n_rem;
        logic [32:0] n_term;

        if (k == 1) begin : g_first
            assign t_in = 33'h1_0000_0000;
            assign y_in = r_y0;
            assign s_in = 34'h1_0000_0000;
        end else begin : g_next
            assign t_in = r_t3[k-1];
            assign y_in = r_y3[k-1];
            assign s_in = r_s3[k-1];
        end

        assign n_q0   = 32'(r_qm2[k] >> SH);
        assign n_rem  = 36'(r_v2[k]) - 36'(n_q0) * 36'(k);
        assign n_term = 33'(n_q0) + 33'(n_rem >= 36'(k));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v1[k]  <= 32'((65'(t_in) * 65'(y_in)) >> 32);
                r_y1[k]  <= y_in;
                r_s1[k]  <= s_in;
                r_qm2[k] <= 68'(r_v1[k]) * 68'(MK);
                r_v2[k]  <= r_v1[k];
                r_y2[k]  <= r_y1[k];
                r_s2[k]  <= r_s1[k];
                r_t3[k]  <= n_term;
                r_y3[k]  <= r_y2[k];
                r_s3[k]  <= r_s2[k] + 34'(n_term);
            end
        end
    end

    assign o_sum = r_s3[NT];

endmodule

/* design/limiter_gain_computer_core.sv */
// channel     | direction | transaction carries
// s_axis      | in        | tdata: sample_in, level_db (Q7.8)
// m_axis      | out       | tdata: sample_out, gain_db (Q7.8); tuser: saturated
// cfg         | in        | index and data of one register write
//
// one item per clock sustained when m_axis does not stall; the pipe includes the 12-stage
// soft-knee divider and the 40-stage exp series (three stages per term)
// synchronous active-low reset clears valid bits and the configuration registers
// a stall on m_axis freezes the whole pipe; nothing is dropped or repeated
`include "limiter_gain_computer_core_defines.svh"

module limiter_gain_computer_core #(
    parameter int SAMPLE_BITS = lgc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // sample_in [SAMPLE_BITS-1:0], level_db next 16 bits, zero pad
    input  logic [((SAMPLE_BITS+23)/8)*8-1:0] i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // sample_out [SAMPLE_BITS-1:0], gain_db next 16 bits, zero pad
    output logic [((SAMPLE_BITS+23)/8)*8-1:0] o_m_axis_tdata,
    // saturated
    output logic [0:0]                       o_m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lgc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lgc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int SB    = SAMPLE_BITS;
    localparam int TW    = ((SAMPLE_BITS + 23) / 8) * 8;
    localparam int QW    = lgc_pkg::DIV_QW;
    localparam int XL    = lgc_pkg::EXP_LAT;
    localparam int PW    = SB + 24;
    localparam int RW    = SB + 5;
    localparam logic [RW-1:0] MAX_R = {6'b0, {(SB-1){1'b1}}};

    // ---------------- configuration registers ----------------
    logic signed [15:0] r_thr;
    logic [12:0]        r_kw;
    logic               r_mode;
    logic signed [13:0] r_mu;

    logic signed [15:0] cfg_thr;
    logic signed [13:0] cfg_mu;

    assign o_cfg_ready = 1'b1;
    assign cfg_thr = $signed(i_cfg_data[15:0]);
    assign cfg_mu  = $signed(i_cfg_data[13:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_kw   <= '0;
            r_mode <= 1'b1;
            r_mu   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lgc_pkg::IDX_THRESHOLD: begin
                    // clamp to -80..0 dB
                    if (cfg_thr > 0)                     r_thr <= '0;
                    else if (cfg_thr < lgc_pkg::THR_MIN) r_thr <= lgc_pkg::THR_MIN;
                    else                                 r_thr <= cfg_thr;
                end
                lgc_pkg::IDX_KNEE_W: begin
                    r_kw <= (i_cfg_data[12:0] > lgc_pkg::KW_MAX) ? lgc_pkg::KW_MAX
                                                                 : i_cfg_data[12:0];
                end
                lgc_pkg::IDX_KNEE_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                lgc_pkg::IDX_MAKEUP: begin
                    if (cfg_mu > lgc_pkg::MU_MAX)      r_mu <= lgc_pkg::MU_MAX;
                    else if (cfg_mu < lgc_pkg::MU_MIN) r_mu <= lgc_pkg::MU_MIN;
                    else                               r_mu <= cfg_mu;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- pipe control ----------------
    // whole pipe advances together; output register is the last stage
    logic r_o_vld;
    logic pipe_en;
    logic in_acc;

    assign pipe_en         = !r_o_vld || i_m_axis_tready;
    assign o_s_axis_tready = pipe_en;
    assign in_acc          = i_s_axis_tvalid && pipe_en;

    // ---------------- stage a: curve region ----------------
    logic signed [SB-1:0] in_s;
    logic signed [15:0]   in_lvl;
    logic signed [16:0]   a_d;
    logic signed [17:0]   a_d2;
    logic signed [17:0]   a_w;
    logic signed [17:0]   a_esum;
    logic                 a_hard;
    logic [1:0]           a_sel;

    assign in_s   = $signed(i_s_axis_tdata[SB-1:0]);
    assign in_lvl = $signed(i_s_axis_tdata[SB+15:SB]);
    assign a_d    = $signed({in_lvl[15], in_lvl}) - $signed({r_thr[15], r_thr});
    assign a_d2   = $signed({a_d, 1'b0});
    assign a_w    = $signed({5'b0, r_kw});
    assign a_esum = a_d2 + a_w;
    // zero knee width falls back to the hard knee
    assign a_hard = r_mode || (r_kw == '0);

    always_comb begin
        if (a_hard) begin
            a_sel = (a_d <= 0) ? lgc_pkg::SEL_ZERO : lgc_pkg::SEL_LIN;
        end else if (a_d2 < -a_w) begin
            a_sel = lgc_pkg::SEL_ZERO;
        end else if (a_d2 <= a_w) begin
            a_sel = lgc_pkg::SEL_SOFT;
        end else begin
            a_sel = lgc_pkg::SEL_LIN;
        end
    end

    logic                 r_a_vld;
    logic signed [SB-1:0] r_a_s;
    logic [1:0]           r_a_sel;
    logic signed [16:0]   r_a_d;
    logic [13:0]          r_a_e;
    logic [12:0]          r_a_w;

    // ---------------- stage b: knee numerator and divisor ----------------
    logic                      r_b_vld;
    logic signed [SB-1:0]      r_b_s;
    logic [1:0]                r_b_sel;
    logic signed [16:0]        r_b_d;
    logic [lgc_pkg::DIV_NW-1:0] r_b_num;
    logic [lgc_pkg::DIV_DW-1:0] r_b_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (pipe_en) begin
            r_a_vld <= in_acc;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_a_s   <= in_s;
            r_a_sel <= a_sel;
            r_a_d   <= a_d;
            r_a_e   <= a_esum[13:0];
            r_a_w   <= r_kw;
            r_b_s   <= r_a_s;
            r_b_sel <= r_a_sel;
            r_b_d   <= r_a_d;
            // e*e + 4w, rounded by the divide by 8w
            r_b_num <= 28'(r_a_e) * 28'(r_a_e) + 28'({r_a_w, 2'b0});
            r_b_den <= {r_a_w, 3'b0};
        end
    end

    // ---------------- divider with matched side line ----------------
    logic [QW-1:0] dv_quo;

    lgc_div #(
        .NW (lgc_pkg::DIV_NW),
        .DW (lgc_pkg::DIV_DW),
        .QW (QW)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_num (r_b_num),
        .i_den (r_b_den),
        .o_quo (dv_quo)
    );

    logic                 r_dv_vld [QW];
    logic signed [SB-1:0] r_dv_s   [QW];
    logic [1:0]           r_dv_sel [QW];
    logic signed [16:0]   r_dv_d   [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QW; i++) r_dv_vld[i] <= 1'b0;
        end else if (pipe_en) begin
            r_dv_vld[0] <= r_b_vld;
            for (int i = 1; i < QW; i++) r_dv_vld[i] <= r_dv_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_dv_s[0]   <= r_b_s;
            r_dv_sel[0] <= r_b_sel;
            r_dv_d[0]   <= r_b_d;
            for (int i = 1; i < QW; i++) begin
                r_dv_s[i]   <= r_dv_s[i-1];
                r_dv_sel[i] <= r_dv_sel[i-1];
                r_dv_d[i]   <= r_dv_d[i-1];
            end
        end
    end

    // ---------------- stage c: reduction plus makeup, 16-bit clamp ----------------
    logic signed [17:0] c_red;
    logic signed [18:0] c_sum;
    logic signed [15:0] c_g;

    always_comb begin
        case (r_dv_sel[QW-1])
            lgc_pkg::SEL_SOFT: c_red = -$signed({6'b0, dv_quo});
            lgc_pkg::SEL_LIN:  c_red = -$signed({r_dv_d[QW-1][16], r_dv_d[QW-1]});
            default:           c_red = '0;
        endcase
    end

    assign c_sum = $signed({c_red[17], c_red}) + $signed({{5{r_mu[13]}}, r_mu});

    always_comb begin
        if (c_sum > 19'sd32767)        c_g = 16'sh7fff;
        else if (c_sum < -19'sd32768)  c_g = -16'sh8000;
        else                           c_g = c_sum[15:0];
    end

    logic                 r_c_vld;
    logic signed [SB-1:0] r_c_s;
    logic signed [15:0]   r_c_g;

    // ---------------- stage d: dB to log2 exponent ----------------
    logic signed [47:0] d_e40;
    logic [47:0]        d_u;

    assign d_e40 = $signed({{32{r_c_g[15]}}, r_c_g})
                 * $signed({18'b0, lgc_pkg::LOG2_10_OVER_20_Q32});
    // bias by 32 in the integer part, round half up from Q40 to Q32
    assign d_u   = 48'(d_e40) + (48'd32 << 40) + 48'd128;

    logic                 r_d_vld;
    logic signed [SB-1:0] r_d_s;
    logic signed [15:0]   r_d_g;
    logic [5:0]           r_d_ip;
    logic [31:0]          r_d_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (pipe_en) begin
            r_c_vld <= r_dv_vld[QW-1];
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_c_s    <= r_dv_s[QW-1];
            r_c_g    <= c_g;
            r_d_s    <= r_c_s;
            r_d_g    <= r_c_g;
            r_d_ip   <= d_u[45:40];
            r_d_frac <= d_u[39:8];
        end
    end

    // ---------------- exp series with matched side line ----------------
    logic [33:0] xs_sum;

    lgc_exp u_exp (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_frac (r_d_frac),
        .o_sum  (xs_sum)
    );

    logic                 r_xv_vld [XL];
    logic signed [SB-1:0] r_xv_s   [XL];
    logic signed [15:0]   r_xv_g   [XL];
    logic [5:0]           r_xv_ip  [XL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < XL; i++) r_xv_vld[i] <= 1'b0;
        end else if (pipe_en) begin
            r_xv_vld[0] <= r_d_vld;
            for (int i = 1; i < XL; i++) r_xv_vld[i] <= r_xv_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_xv_s[0]  <= r_d_s;
            r_xv_g[0]  <= r_d_g;
            r_xv_ip[0] <= r_d_ip;
            for (int i = 1; i < XL; i++) begin
                r_xv_s[i]  <= r_xv_s[i-1];
                r_xv_g[i]  <= r_xv_g[i-1];
                r_xv_ip[i] <= r_xv_ip[i-1];
            end
        end
    end

    // ---------------- stage f: scale to Q4.20 with rounding ----------------
    logic [5:0]  f_sh;
    logic [45:0] f_t;
    logic [45:0] f_r;
    logic [23:0] f_lin;

    assign f_sh = 6'd44 - r_xv_ip[XL-1];
    assign f_t  = 46'(xs_sum) + (46'd1 << (f_sh - 6'd1));
    assign f_r  = f_t >> f_sh;

    always_comb begin
        if (r_xv_ip[XL-1] >= 6'd44)   f_lin = 24'hffffff;
        else if (f_r > 46'hffffff)    f_lin = 24'hffffff;
        else                          f_lin = f_r[23:0];
    end

    logic                 r_f_vld;
    logic signed [SB-1:0] r_f_s;
    logic signed [15:0]   r_f_g;
    logic [23:0]          r_f_lin;

    // ---------------- stage g: magnitude times gain ----------------
    logic [SB-1:0] g_mag;

    assign g_mag = r_f_s[SB-1] ? SB'(-r_f_s) : SB'(r_f_s);

    logic               r_g_vld;
    logic               r_g_neg;
    logic [PW-1:0]      r_g_prod;
    logic signed [15:0] r_g_g;

    // ---------------- stage h: round, saturate, output register ----------------
    logic [PW:0]     h_t;
    logic [RW-1:0]   h_r;
    logic [SB-1:0]   h_v;
    logic            h_sat;

    assign h_t = (PW+1)'(r_g_prod) + (PW+1)'(20'h80000);
    assign h_r = RW'(h_t >> 20);

    always_comb begin
        if (r_g_neg) begin
            h_sat = h_r > (MAX_R + RW'(1));
            h_v   = h_sat ? {1'b1, {(SB-1){1'b0}}} : SB'(-h_r[SB-1:0]);
        end else begin
            h_sat = h_r > MAX_R;
            h_v   = h_sat ? {1'b0, {(SB-1){1'b1}}} : h_r[SB-1:0];
        end
    end

    logic [SB-1:0] r_o_s;
    logic [15:0]   r_o_g;
    logic          r_o_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (pipe_en) begin
            r_f_vld <= r_xv_vld[XL-1];
            r_g_vld <= r_f_vld;
            r_o_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_f_s    <= r_xv_s[XL-1];
            r_f_g    <= r_xv_g[XL-1];
            r_f_lin  <= f_lin;
            r_g_neg  <= r_f_s[SB-1];
            r_g_prod <= PW'(g_mag) * PW'(r_f_lin);
            r_g_g    <= r_f_g;
            r_o_s    <= h_v;
            r_o_g    <= r_g_g;
            r_o_sat  <= h_sat;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = TW'({r_o_g, r_o_s});
    assign o_m_axis_tuser  = r_o_sat;

    // ---------------- assertions ----------------
    `LGC_ASSERT_IMP(a_sat_at_rail, i_clk, i_rst_n, o_m_axis_tvalid && r_o_sat,
        (r_o_s == {1'b1, {(SB-1){1'b0}}}) || (r_o_s == {1'b0, {(SB-1){1'b1}}}),
        "saturated output not at a rail")
    `LGC_ASSERT_IMP(a_sat_needs_gain, i_clk, i_rst_n, o_m_axis_tvalid && r_o_sat,
        !r_o_g[15], "clipping with negative gain")
    `LGC_ASSERT_IMP(a_gain_below_makeup, i_clk, i_rst_n, o_m_axis_tvalid,
        $signed(r_o_g) <= $signed({{2{r_mu[13]}}, r_mu}),
        "gain above makeup")
    `LGC_ASSERT_NXT(a_thr_range, i_clk, i_rst_n,
        i_cfg_valid && (i_cfg_index == lgc_pkg::IDX_THRESHOLD),
        (r_thr <= 0) && (r_thr >= lgc_pkg::THR_MIN), "threshold out of range")

endmodule
